// ===== hdl/rtu_pkg.sv =====
// Package with the entry layout, cell control and controller states of the route table.
package rtu_pkg;

   typedef struct packed {
      logic [31:0] network;
      logic [5:0]  prefix;
      logic [31:0] next_hop;
      logic [15:0] weight;
   } entry_type;

   typedef struct packed {
      logic rotate;
      logic update;
      logic do_delete;
      logic do_insert;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE,
      ST_DUMP
   } rtu_state_type;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 96;

endpackage

// ===== hdl/rtu_cell.sv =====
// One cell of the route table chain: holds one entry and passes it toward the head.
module rtu_cell
   import rtu_pkg::*;
#(
   parameter int IW  = 6,
   parameter int IDX = 0
) (
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic [IW-1:0]       del_pos,
   input  logic [IW-1:0]       ins_idx,
   input  entry_type           new_entry,
   input  entry_type           nbr_entry,
   output entry_type           entry
);

   localparam logic [IW-1:0] MY_IDX = IW'(IDX);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.rotate) begin
         entry_in = nbr_entry;
      end else if (ctrl.update) begin
         if (ctrl.do_insert && MY_IDX == ins_idx) begin
            entry_in = new_entry;
         end else if (ctrl.do_delete && MY_IDX >= del_pos && MY_IDX < ins_idx) begin
            entry_in = nbr_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== hdl/route_table_update_top.sv =====
// Top level of the route table: controller, output register and the chain of entry cells.
//
// Requests arrive as words on the req_ channel: tuser selects add (0) or dump (1).
// Results leave as words on the rsp_ channel, with tlast on the final word of a request.
// The table is a ring of TABLE_DEPTH cells; cell 0 is the head.
// An add rotates the ring once around to find the first entry with the same masked
// network. Once the output register is free, it then deletes a matching entry of larger
// weight and appends the request, or appends it when none matched and the table has
// room, and emits one word.
// A dump of a non-empty table rotates the ring once around and emits one word per
// stored entry; an empty table gives a single word with entry_valid low.
// One request is handled at a time: req_tready is high only while the block is idle.
// When the receiver stalls, the result waits in the output register; while a dump
// still has entries to emit, the ring holds still until the word is taken.
// Reset empties the table and the output register; entry contents are not cleared.
module route_table_update_top
   import rtu_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // net_addr[31:0], prefix_len[37:32], next_hop[69:38], route_weight[85:70]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type[0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // accepted[0], table_full[1], entry_valid[2], out_network[34:3], out_prefix[40:35],
   // out_next_hop[72:41], out_weight[88:73], entry_total[95:89]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [IW-1:0] LAST_STEP = IW'(TABLE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

   rtu_state_type state_ff, state_in;
   logic [IW-1:0] step_ff, step_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic          found_ff, found_in;
   logic [15:0]   mweight_ff, mweight_in;
   entry_type     req_ff, req_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   cell_ctrl_type ctrl;
   logic [IW-1:0] ins_idx;
   entry_type     cell_q [TABLE_DEPTH];
   entry_type     head;
   logic          out_free;
   logic          last_step;
   logic          step_lt_count;
   logic          replace;
   logic          full;
   logic          add_new;
   logic [31:0]   mask;

   assign head          = cell_q[0];
   assign out_free      = !rsp_valid_ff || rsp_tready;
   assign last_step     = step_ff == LAST_STEP;
   assign step_lt_count = CW'(step_ff) < count_ff;
   assign replace       = found_ff && (mweight_ff > req_ff.weight);
   assign full          = !found_ff && (count_ff >= FULL_COUNT);
   assign add_new       = !found_ff && !full;
   assign ins_idx       = count_ff[IW-1:0] - IW'(replace);
   assign mask          = ~(32'hFFFF_FFFF >> req_tdata[37:32]);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      mweight_in   = mweight_ff;
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      ctrl         = '0;
      req_tready   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               req_in.network  = req_tdata[31:0] & mask;
               req_in.prefix   = req_tdata[37:32];
               req_in.next_hop = req_tdata[69:38];
               req_in.weight   = req_tdata[85:70];
               step_in         = '0;
               found_in        = 1'b0;
               state_in        = req_tuser ? ST_DUMP : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            ctrl.rotate = 1'b1;
            if (!found_ff && step_lt_count && head.network == req_ff.network) begin
               found_in   = 1'b1;
               pos_in     = step_ff;
               mweight_in = head.weight;
            end
            step_in = step_ff + 1'b1;
            if (last_step) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               ctrl.update    = 1'b1;
               ctrl.do_delete = replace;
               ctrl.do_insert = replace || add_new;
               count_in       = add_new ? count_ff + 1'b1 : count_ff;
               rsp_valid_in   = 1'b1;
               rsp_last_in    = 1'b1;
               rsp_data_in    = {7'(count_in), 16'd0, 32'd0, 6'd0, 32'd0,
                                 1'b0, full, replace || add_new};
               state_in       = ST_IDLE;
            end
         end
         ST_DUMP: begin
            if (count_ff == '0) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  rsp_data_in  = '0;
                  state_in     = ST_IDLE;
               end
            end else if (!step_lt_count || out_free) begin
               ctrl.rotate = 1'b1;
               step_in     = step_ff + 1'b1;
               if (step_lt_count) begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = CW'(step_ff) == count_ff - 1'b1;
                  rsp_data_in  = {7'(count_ff), head.weight, head.next_hop, head.prefix,
                                  head.network, 1'b1, 1'b0, 1'b0};
               end
               if (last_step) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         found_ff     <= found_in;
      end
      pos_ff      <= pos_in;
      mweight_ff  <= mweight_in;
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      rtu_cell #(
         .IW  (IW),
         .IDX (i)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .del_pos   (pos_ff),
         .ins_idx   (ins_idx),
         .new_entry (req_ff),
         .nbr_entry (cell_q[(i + 1) % TABLE_DEPTH]),
         .entry     (cell_q[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== dv/route_table_update_top_tb.sv =====
// Self-checking testbench for the route table: directed, stall, random and full-table request streams.
module route_table_update_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rtu_pkg::*;

   localparam int   TABLE_DEPTH = 64;
   localparam logic REQ_ADD     = 1'b0;
   localparam logic REQ_DUMP    = 1'b1;
   localparam int   CYCLE_LIMIT = 3_000_000;
   localparam int   HOLD_CYCLES = 300;
   localparam int   POOL_SIZE   = 48;

   typedef struct packed {
      logic        accepted;
      logic        table_full;
      logic        entry_valid;
      logic [31:0] network;
      logic [5:0]  prefix;
      logic [31:0] next_hop;
      logic [15:0] weight;
      logic        last;
      logic [6:0]  total;
   } route_result_type;

   typedef enum {SINK_STEADY, SINK_RANDOM, SINK_PERIODIC} sink_mode_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   entry_type        route_list[$];
   route_result_type pending_results[$];
   logic [31:0]      pool_addr[$];
   logic [5:0]       pool_prefix[$];
   int               error_count = 0;
   int               cycle_count = 0;
   int               burst_left  = 0;
   bit               hold_request = 1'b0;

   route_table_update_top #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] masked_network(input logic [31:0] addr,
                                                   input logic [5:0] prefix);
      if (prefix >= 6'd32) return addr;
      return addr & ~(32'hFFFF_FFFF >> prefix);
   endfunction

   function automatic void apply_route_update(input entry_type route);
      route_result_type res;
      int hit;
      res = '0;
      hit = -1;
      for (int i = 0; i < route_list.size(); i++) begin
         if (route_list[i].network == route.network) begin
            hit = i;
            break;
         end
      end
      if (hit >= 0) begin
         if (route_list[hit].weight > route.weight) begin
            route_list.delete(hit);
            route_list.push_back(route);
            res.accepted = 1'b1;
         end
      end else if (route_list.size() >= TABLE_DEPTH) begin
         res.table_full = 1'b1;
      end else begin
         route_list.push_back(route);
         res.accepted = 1'b1;
      end
      res.last  = 1'b1;
      res.total = 7'(route_list.size());
      pending_results.push_back(res);
   endfunction

   function automatic void expect_table_dump();
      route_result_type res;
      if (route_list.size() == 0) begin
         res = '0;
         res.last = 1'b1;
         pending_results.push_back(res);
         return;
      end
      for (int i = 0; i < route_list.size(); i++) begin
         res = '0;
         res.entry_valid = 1'b1;
         res.network     = route_list[i].network;
         res.prefix      = route_list[i].prefix;
         res.next_hop    = route_list[i].next_hop;
         res.weight      = route_list[i].weight;
         res.last        = (i == route_list.size() - 1);
         res.total       = 7'(route_list.size());
         pending_results.push_back(res);
      end
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("%0t ns: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
   endtask

   task automatic send_word(input logic kind, input logic [31:0] addr, input logic [5:0] prefix,
                            input logic [31:0] hop, input logic [15:0] weight);
      entry_type route;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, weight, hop, prefix, addr};
      do @(posedge clock); while (!req_tready);
      if (kind == REQ_DUMP) begin
         expect_table_dump();
      end else begin
         route.network  = masked_network(addr, prefix);
         route.prefix   = prefix;
         route.next_hop = hop;
         route.weight   = weight;
         apply_route_update(route);
      end
   endtask

   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_dump();
      send_word(REQ_DUMP, $urandom, 6'($urandom), $urandom, 16'($urandom));
   endtask

   task automatic test_directed_cases();
      send_dump();
      send_word(REQ_ADD, 32'h0A01_0203, 6'd8, 32'h0000_0000, 16'd100);
      send_word(REQ_ADD, 32'h0A00_0000, 6'd16, 32'h0101_0101, 16'd100);
      send_word(REQ_ADD, 32'h0A00_0000, 6'd16, 32'h0101_0101, 16'd101);
      send_word(REQ_ADD, 32'h0A00_0000, 6'd16, 32'h0202_0202, 16'd50);
      send_word(REQ_ADD, 32'hFFFF_FFFF, 6'd0, 32'hFFFF_FFFF, 16'hFFFF);
      send_word(REQ_ADD, 32'h1234_5678, 6'd0, 32'h0303_0303, 16'hFFFE);
      send_word(REQ_ADD, 32'hFFFF_FFFF, 6'd32, 32'h0404_0404, 16'd0);
      send_word(REQ_ADD, 32'hFFFF_FFFF, 6'd32, 32'h0505_0505, 16'd0);
      send_word(REQ_ADD, 32'hC0A8_0101, 6'd63, 32'h0606_0606, 16'd9);
      send_word(REQ_ADD, 32'hC0A8_0101, 6'd33, 32'h0707_0707, 16'd9);
      send_word(REQ_ADD, 32'hFFFF_FFFF, 6'd31, 32'h0808_0808, 16'd7);
      send_word(REQ_ADD, 32'h8000_0000, 6'd1, 32'h0909_0909, 16'd3);
      send_dump();
      send_word(REQ_ADD, 32'hAAAA_AAAA, 6'd24, 32'h5555_5555, 16'hAAAA);
      send_word(REQ_ADD, 32'h5555_5555, 6'd24, 32'hAAAA_AAAA, 16'h5555);
      send_word(REQ_ADD, 32'hAAAA_AAFF, 6'd24, 32'h1111_1111, 16'h0001);
      send_dump();
      wait_all_results();
   endtask

   task automatic test_receiver_hold();
      hold_request = 1'b1;
      repeat (6) send_word(REQ_ADD, $urandom, 6'($urandom_range(0, 63)), $urandom,
                           16'($urandom));
      send_dump();
      wait_all_results();
   endtask

   task automatic test_random_updates(input int count);
      logic [31:0] addr;
      logic [5:0]  prefix;
      logic [15:0] weight;
      int roll;
      int k;
      repeat (count) begin
         roll   = $urandom_range(0, 99);
         weight = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
         if (roll < 8) begin
            send_dump();
         end else if (roll < 70 && pool_addr.size() > 0) begin
            k      = $urandom_range(0, pool_addr.size() - 1);
            prefix = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63)) : pool_prefix[k];
            addr   = masked_network(pool_addr[k], prefix)
                     | ($urandom & ~masked_network(32'hFFFF_FFFF, prefix));
            send_word(REQ_ADD, addr, prefix, $urandom, weight);
         end else begin
            addr   = $urandom;
            prefix = 6'($urandom_range(0, 63));
            if (pool_addr.size() < POOL_SIZE) begin
               pool_addr.push_back(addr);
               pool_prefix.push_back(prefix);
            end
            send_word(REQ_ADD, addr, prefix, $urandom, weight);
         end
      end
      wait_all_results();
   endtask

   task automatic test_full_table();
      entry_type held;
      while (route_list.size() < TABLE_DEPTH) begin
         send_word(REQ_ADD, $urandom, 6'($urandom_range(8, 63)), $urandom, 16'($urandom));
      end
      repeat (5) send_word(REQ_ADD, $urandom, 6'($urandom_range(8, 63)), $urandom,
                           16'($urandom));
      repeat (6) begin
         held = route_list[$urandom_range(0, route_list.size() - 1)];
         send_word(REQ_ADD, held.network, held.prefix, $urandom,
                   (held.weight == 16'd0) ? 16'd0 : held.weight - 16'd1);
      end
      send_dump();
      wait_all_results();
   endtask

   initial begin : result_sink
      sink_mode_type mode;
      int hold_left;
      int mode_left;
      int period;
      int phase;
      rsp_tready <= 1'b0;
      mode      = SINK_STEADY;
      hold_left = 0;
      mode_left = 0;
      period    = 1;
      phase     = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = sink_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 200);
            period    = $urandom_range(2, 8);
         end
         mode_left--;
         phase++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               SINK_STEADY: rsp_tready <= 1'b1;
               SINK_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
               default:     rsp_tready <= (phase % period == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : result_check
      route_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("word %h arrived with nothing expected", rsp_tdata));
         end else begin
            want = pending_results.pop_front();
            check_field("accepted", 32'(rsp_tdata[0]), 32'(want.accepted));
            check_field("table_full", 32'(rsp_tdata[1]), 32'(want.table_full));
            check_field("entry_valid", 32'(rsp_tdata[2]), 32'(want.entry_valid));
            check_field("out_network", rsp_tdata[34:3], want.network);
            check_field("out_prefix", 32'(rsp_tdata[40:35]), 32'(want.prefix));
            check_field("out_next_hop", rsp_tdata[72:41], want.next_hop);
            check_field("out_weight", 32'(rsp_tdata[88:73]), 32'(want.weight));
            check_field("entry_total", 32'(rsp_tdata[95:89]), 32'(want.total));
            check_field("last", 32'(rsp_tlast), 32'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[route_table_update_top] ERROR");
         $finish;
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= REQ_ADD;
      req_tdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_receiver_hold();
      test_random_updates(360);
      test_full_table();
      wait_all_results();
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("[route_table_update_top] OK");
      end else begin
         $display("[route_table_update_top] ERROR");
      end
      $finish;
   end

endmodule
